// ===== design/assert_macros.svh =====
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define CPFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define CPFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/cpfd_pkg.sv =====
// shared types and constants of the command packet framer and deframer
package cpfd_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'h0F;
    localparam logic [7:0] END_BYTE       = 8'h00;
    localparam int         PAYLOAD_LEN    = 12;
    localparam int         PKT_LEN        = 16;
    localparam int         QUEUE_DEPTH_DEF = 2;

    // input item
    typedef struct packed {
        logic        func;
        logic [7:0]  rx_byte;
        logic [7:0]  cmd_code;
        logic [63:0] payload_low;
        logic [31:0] payload_high;
    } item_t;

    // result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [7:0]  resp_cmd;
        logic [63:0] resp_low;
        logic [31:0] resp_high;
    } result_t;

    // job handed from front to back: a frame to send or a response to report
    typedef struct packed {
        logic                        is_resp;
        logic [7:0]                  cmd;
        logic [PAYLOAD_LEN*8-1:0]    payload;
    } job_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

// ===== design/cpfd_front.sv =====
// front part: accepts items, tracks the receive search and checks packets
module cpfd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  cpfd_pkg::item_t item,
    input  logic            queue_full,
    output logic            push,
    output cpfd_pkg::job_t  push_job
);
    import cpfd_pkg::*;

    logic [3:0]                   count_reg, count_next;
    logic                         held_reg, held_next;
    logic [7:0]                   sent_cmd_reg, sent_cmd_next;
    logic [PAYLOAD_LEN-1:0][7:0]  sent_pl_reg, sent_pl_next;
    logic [7:0]                   sum_reg, sum_next;
    logic                         cmd_ok_reg, cmd_ok_next;
    logic                         cks_ok_reg, cks_ok_next;
    logic                         diff_reg, diff_next;
    logic [7:0]                   rx_cmd_reg;
    logic [PAYLOAD_LEN-1:0][7:0]  rx_pl_reg;

    logic       accept;
    logic       rx_take;
    logic [3:0] pidx;
    logic [7:0] sent_byte;
    logic       pkt_ok;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;
    assign rx_take    = accept && !item.func && !held_reg;
    assign pidx       = count_reg - 4'd2;
    assign sent_byte  = (pidx < 4'(PAYLOAD_LEN)) ? sent_pl_reg[pidx] : 8'h00;
    assign pkt_ok     = (item.rx_byte == END_BYTE) && cmd_ok_reg && cks_ok_reg && diff_reg;

    // receive search, per byte checks and send capture
    always_comb
    begin
        count_next    = count_reg;
        held_next     = held_reg;
        sent_cmd_next = sent_cmd_reg;
        sent_pl_next  = sent_pl_reg;
        sum_next      = sum_reg;
        cmd_ok_next   = cmd_ok_reg;
        cks_ok_next   = cks_ok_reg;
        diff_next     = diff_reg;
        push          = 1'b0;
        push_job      = '0;
        if (accept && item.func)
        begin
            sent_cmd_next    = item.cmd_code;
            sent_pl_next     = {item.payload_high, item.payload_low};
            count_next       = 4'd0;
            held_next        = 1'b0;
            push             = 1'b1;
            push_job.is_resp = 1'b0;
            push_job.cmd     = item.cmd_code;
            push_job.payload = {item.payload_high, item.payload_low};
        end
        else if (rx_take)
        begin
            case (count_reg)
                4'd0:
                begin
                    if (item.rx_byte == SYNC_BYTE)
                    begin
                        count_next = 4'd1;
                    end
                end
                4'd1:
                begin
                    cmd_ok_next = (item.rx_byte == sent_cmd_reg);
                    sum_next    = item.rx_byte;
                    diff_next   = 1'b0;
                    count_next  = 4'd2;
                end
                4'd14:
                begin
                    cks_ok_next = (item.rx_byte == sum_reg);
                    count_next  = 4'd15;
                end
                4'd15:
                begin
                    count_next = 4'd0;
                    if (pkt_ok)
                    begin
                        held_next        = 1'b1;
                        push             = 1'b1;
                        push_job.is_resp = 1'b1;
                        push_job.cmd     = rx_cmd_reg;
                        push_job.payload = rx_pl_reg;
                    end
                end
                default:
                begin
                    sum_next   = sum_reg + item.rx_byte;
                    diff_next  = diff_reg || (item.rx_byte != sent_byte);
                    count_next = count_reg + 4'd1;
                end
            endcase
        end
    end

    // control and sent-packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= 4'd0;
            held_reg     <= 1'b0;
            sent_cmd_reg <= 8'h00;
            sent_pl_reg  <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            held_reg     <= held_next;
            sent_cmd_reg <= sent_cmd_next;
            sent_pl_reg  <= sent_pl_next;
        end
    end

    // running checks and received bytes
    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        cmd_ok_reg <= cmd_ok_next;
        cks_ok_reg <= cks_ok_next;
        diff_reg   <= diff_next;
        if (rx_take && count_reg == 4'd1)
        begin
            rx_cmd_reg <= item.rx_byte;
        end
        if (rx_take && count_reg >= 4'd2 && count_reg <= 4'd13)
        begin
            rx_pl_reg[pidx] <= item.rx_byte;
        end
    end

endmodule

// ===== design/cpfd_queue.sv =====
// short job queue between front and back
module cpfd_queue #(
    parameter int DEPTH = cpfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  cpfd_pkg::job_t          push_job,
    input  logic                    pop,
    output cpfd_pkg::job_t          head,
    output cpfd_pkg::queue_status_t status
);
    import cpfd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push, do_pop;

    assign status.full  = (fill_reg == CW'(DEPTH));
    assign status.valid = (fill_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== design/cpfd_back.sv =====
// back part: serializes send frames and reports responses through an output register
module cpfd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  cpfd_pkg::job_t    job,
    output logic              pop,
    output logic              mid_frame,
    output logic              result_valid,
    input  logic              result_stall,
    output cpfd_pkg::result_t result
);
    import cpfd_pkg::*;

    logic [3:0] idx_reg, idx_next;
    logic [7:0] sum_reg, sum_next;
    logic       valid_reg, valid_next;
    result_t    result_reg, result_next;
    logic       load;
    logic [3:0] pi;
    logic [7:0] cur_byte;

    assign load         = job_valid && (!valid_reg || !result_stall);
    assign pi           = idx_reg - 4'd2;
    assign mid_frame    = (idx_reg != 4'd0);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    // byte of the frame at the current position
    always_comb
    begin
        case (idx_reg)
            4'd0:    cur_byte = SYNC_BYTE;
            4'd1:    cur_byte = job.cmd;
            4'd14:   cur_byte = sum_reg;
            4'd15:   cur_byte = END_BYTE;
            default: cur_byte = job.payload[8*pi +: 8];
        endcase
    end

    // next output item, frame position and checksum
    always_comb
    begin
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        result_next = result_reg;
        valid_next  = result_stall ? valid_reg : 1'b0;
        pop         = 1'b0;
        if (load)
        begin
            valid_next  = 1'b1;
            result_next = '0;
            if (job.is_resp)
            begin
                result_next.kind      = 1'b1;
                result_next.last      = 1'b1;
                result_next.resp_cmd  = job.cmd;
                result_next.resp_low  = job.payload[63:0];
                result_next.resp_high = job.payload[95:64];
                pop                   = 1'b1;
            end
            else
            begin
                result_next.tx_byte = cur_byte;
                result_next.last    = (idx_reg == 4'(PKT_LEN - 1));
                if (idx_reg == 4'd0)
                begin
                    sum_next = 8'h00;
                end
                else if (idx_reg <= 4'd13)
                begin
                    sum_next = sum_reg + cur_byte;
                end
                if (idx_reg == 4'(PKT_LEN - 1))
                begin
                    pop      = 1'b1;
                    idx_next = 4'd0;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

endmodule

// ===== design/command_packet_framer_deframer_core.sv =====
// top level of the command packet framer and deframer
// result path: with the back part idle, an accepted item is written into the job queue,
// and the back part then loads its first result into the output register
// throughput: one item per cycle while the job queue has room; a send holds the back
// part for a whole frame (one byte per cycle unless stalled), a response for one item
// reset: asynchronous, clears the receive search, the held flag, the sent command
// and payload, the queue and the output valid; no clearing pass is needed
module command_packet_framer_deframer_core #(
    parameter int QUEUE_DEPTH = cpfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cpfd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output cpfd_pkg::result_t result
);
    import cpfd_pkg::*;

    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          head;
    queue_status_t q_status;
    logic          mid_frame;

    // item intake and receive checks
    cpfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (q_status.full),
        .push       (push),
        .push_job   (push_job)
    );

    // job queue
    cpfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // frame serializer and response reporting
    cpfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_status.valid),
        .job          (head),
        .pop          (pop),
        .mid_frame    (mid_frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `include "assert_macros.svh"

    // front never pushes into a full queue
    `CPFD_ASSERT(a_no_overflow, clk, rst_n, !(push && q_status.full), "push into full queue")
    // inside a frame the queue head is a send job
    `CPFD_ASSERT(a_frame_head, clk, rst_n,
        mid_frame |-> (q_status.valid && !head.is_resp), "frame without send job")
    // a new output item only comes from a queued job
    `CPFD_ASSERT(a_out_source, clk, rst_n,
        $rose(result_valid) |-> $past(q_status.valid), "output without job")

endmodule
